// ----- sv/hsv2rgb_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the hsv to rgb converter
package hsv2rgb_pkg;

   localparam int HUE_W  = 20;
   localparam int LVL_W  = 17;
   localparam int CHAN_W = 8;

   // Q1.16 unity for saturation and brightness
   localparam logic [LVL_W-1:0] Q_ONE = 17'h10000;
   localparam int Q_SHIFT = 16;

   // exact floor(y / 15) for y below 4681: (y * 2185) >> 15
   localparam int DIV15_Y_W   = 12;
   localparam int DIV15_MUL_W = 12;
   localparam logic [DIV15_MUL_W-1:0] DIV15_MUL = 12'd2185;
   localparam int DIV15_SHIFT = 15;
   localparam int DIV15_P_W   = DIV15_Y_W + DIV15_MUL_W;

   // depth of the queue between front and back
   localparam int FIFO_DEPTH = 2;

   // 60 degree hue sectors
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic signed [HUE_W-1:0] hue;
      logic [LVL_W-1:0]        saturation;
      logic [LVL_W-1:0]        brightness;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

// ----- sv/hsv2rgb_front.sv -----
`timescale 1ns / 1ps
// front end: clamps levels, wraps the hue and splits it into sector and remainder
module hsv2rgb_front #(
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  hsv2rgb_pkg::req_type              req_data,
   output logic                              push,
   output hsv2rgb_pkg::sector_type           sector,
   output logic [$clog2(60 << HUE_FRAC_BITS)-1:0] rem,
   output logic [hsv2rgb_pkg::LVL_W-1:0]     sat,
   output logic [hsv2rgb_pkg::LVL_W-1:0]     bri
);

   localparam int HW    = hsv2rgb_pkg::HUE_W;
   localparam int LW    = hsv2rgb_pkg::LVL_W;
   localparam int TURN  = 360 << HUE_FRAC_BITS;
   localparam int SEC   = 60 << HUE_FRAC_BITS;
   localparam int HALF  = 2 ** (HW - 1);
   localparam int EXTRA = ((HALF + TURN - 1) / TURN) * TURN - HALF;
   localparam int UW    = HW + 1;
   localparam int RS    = UW + 1;
   localparam int M     = (2 ** RS) / TURN;
   localparam int MW    = $clog2(M + 1);
   localparam int QW    = $clog2((2 ** UW) / TURN + 1);
   localparam int TW    = $clog2(TURN);
   localparam int RW    = $clog2(SEC);

   // stage 0: biased hue and clamped levels
   logic          valid0_ff, valid0_in;
   logic [UW-1:0] u0_ff, u0_in;
   logic [LW-1:0] s0_ff, s0_in, v0_ff, v0_in;
   // stage 1: turn count estimate
   logic          valid1_ff;
   logic [UW-1:0] u1_ff;
   logic [QW-1:0] q1_ff, q1_in;
   logic [LW-1:0] s1_ff, v1_ff;
   logic [UW+MW-1:0] prod1;
   // stage 2: remainder, below two turns
   logic            valid2_ff;
   logic [TW:0]     r2_ff, r2_in;
   logic [UW-1:0]   qt2;
   logic [LW-1:0]   s2_ff, v2_ff;
   logic [TW-1:0]   hm;

   // offset by a whole number of turns so the hue is never negative
   assign u0_in = UW'({~req_data.hue[HW-1], req_data.hue[HW-2:0]}) + UW'(EXTRA);
   assign s0_in = (req_data.saturation > hsv2rgb_pkg::Q_ONE) ? hsv2rgb_pkg::Q_ONE
                                                              : req_data.saturation;
   assign v0_in = (req_data.brightness > hsv2rgb_pkg::Q_ONE) ? hsv2rgb_pkg::Q_ONE
                                                              : req_data.brightness;
   assign valid0_in = accept;

   // reciprocal estimate, low by at most one turn
   assign prod1 = (UW+MW)'(u0_ff) * (UW+MW)'(M);
   assign q1_in = QW'(prod1 >> RS);

   assign qt2   = UW'(UW'(q1_ff) * UW'(TURN));
   assign r2_in = (TW+1)'(u1_ff - qt2);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid0_ff <= valid0_in;
         valid1_ff <= valid0_ff;
         valid2_ff <= valid1_ff;
      end
      u0_ff <= u0_in;
      s0_ff <= s0_in;
      v0_ff <= v0_in;
      u1_ff <= u0_ff;
      q1_ff <= q1_in;
      s1_ff <= s0_ff;
      v1_ff <= v0_ff;
      r2_ff <= r2_in;
      s2_ff <= s1_ff;
      v2_ff <= v1_ff;
   end

   // final correction and sector split feed the queue directly
   assign hm = (r2_ff >= (TW+1)'(TURN)) ? TW'(r2_ff - (TW+1)'(TURN)) : TW'(r2_ff);

   always_comb begin
      priority if (hm >= TW'(5 * SEC)) begin
         sector = hsv2rgb_pkg::SEC_MAG_RED;
         rem    = RW'(hm - TW'(5 * SEC));
      end else if (hm >= TW'(4 * SEC)) begin
         sector = hsv2rgb_pkg::SEC_BLU_MAG;
         rem    = RW'(hm - TW'(4 * SEC));
      end else if (hm >= TW'(3 * SEC)) begin
         sector = hsv2rgb_pkg::SEC_CYN_BLU;
         rem    = RW'(hm - TW'(3 * SEC));
      end else if (hm >= TW'(2 * SEC)) begin
         sector = hsv2rgb_pkg::SEC_GRN_CYN;
         rem    = RW'(hm - TW'(2 * SEC));
      end else if (hm >= TW'(SEC)) begin
         sector = hsv2rgb_pkg::SEC_YEL_GRN;
         rem    = RW'(hm - TW'(SEC));
      end else begin
         sector = hsv2rgb_pkg::SEC_RED_YEL;
         rem    = RW'(hm);
      end
   end

   assign push = valid2_ff;
   assign sat  = s2_ff;
   assign bri  = v2_ff;

endmodule

// ----- sv/hsv2rgb_fifo.sv -----
`timescale 1ns / 1ps
// small register queue between front and back
module hsv2rgb_fifo #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             rd_data,
   output hsv2rgb_pkg::fifo_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign status.empty = (count_ff == CW'(0));
   assign status.full  = (count_ff == CW'(DEPTH));
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   assign wr_ptr_in = !do_push ? wr_ptr_ff
                    : (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
   assign rd_ptr_in = !do_pop ? rd_ptr_ff
                    : (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
   assign count_in  = count_ff + CW'(do_push) - CW'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = entry_ff[rd_ptr_ff];

endmodule

// ----- sv/hsv2rgb_back.sv -----
`timescale 1ns / 1ps
// back end: forms the three channel levels, scales by 255 and routes by sector
module hsv2rgb_back #(
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take,
   input  hsv2rgb_pkg::sector_type           sector,
   input  logic [$clog2(60 << HUE_FRAC_BITS)-1:0] rem,
   input  logic [hsv2rgb_pkg::LVL_W-1:0]     sat,
   input  logic [hsv2rgb_pkg::LVL_W-1:0]     bri,
   output logic                              rsp_strobe,
   output hsv2rgb_pkg::rsp_type              rsp_data
);

   localparam int LW  = hsv2rgb_pkg::LVL_W;
   localparam int CW  = hsv2rgb_pkg::CHAN_W;
   localparam int QS  = hsv2rgb_pkg::Q_SHIFT;
   localparam int YW  = hsv2rgb_pkg::DIV15_Y_W;
   localparam int PW  = hsv2rgb_pkg::DIV15_P_W;
   localparam int SEC = 60 << HUE_FRAC_BITS;
   localparam int RW  = $clog2(SEC);
   localparam int DW  = $clog2(SEC + 1);
   localparam int NW  = QS + DW;          // width of one times sector span
   localparam int AW  = LW + RW;          // s * rem
   localparam int BW  = LW + DW;          // s * (span - rem)
   localparam int V1W = 2 * LW;           // v * (1 - s)
   localparam int MW  = LW + NW;          // v * numerator
   localparam int DSH = 2 * QS + 2 + HUE_FRAC_BITS;  // denominator is 15 << DSH

   // stage 0
   logic             valid0_ff;
   hsv2rgb_pkg::sector_type sec0_ff;
   logic [LW-1:0]    v0_ff;
   logic [AW-1:0]    pa0_ff, pa0_in;
   logic [BW-1:0]    pb0_ff, pb0_in;
   logic [V1W-1:0]   pv0_ff, pv0_in;
   logic [CW-1:0]    cv0_ff, cv0_in;
   logic [LW+7:0]    v255;
   // stage 1
   logic             valid1_ff;
   hsv2rgb_pkg::sector_type sec1_ff;
   logic [MW-1:0]    m2_1_ff, m2_1_in, m3_1_ff, m3_1_in;
   logic [NW-1:0]    n2, n3;
   logic [CW-1:0]    c1_1_ff, c1_1_in, cv1_ff;
   logic [V1W+7:0]   pv255;
   // stage 2
   logic             valid2_ff;
   hsv2rgb_pkg::sector_type sec2_ff;
   logic [MW+7:0]    x2, x3;
   logic [YW-1:0]    y2, y3;
   logic [PW-1:0]    d2_2_ff, d2_2_in, d3_2_ff, d3_2_in;
   logic [CW-1:0]    c1_2_ff, cv2_ff;
   // stage 3
   logic [CW-1:0]    c2, c3;
   hsv2rgb_pkg::rsp_type rsp_in;

   // stage 0 products
   assign pa0_in = AW'(sat) * AW'(rem);
   assign pb0_in = BW'(sat) * BW'(DW'(SEC) - DW'(rem));
   assign pv0_in = V1W'(bri) * V1W'(hsv2rgb_pkg::Q_ONE - sat);
   assign v255   = {bri, 8'b0} - (LW+8)'(bri);
   assign cv0_in = CW'(v255 >> QS);

   // stage 1: numerators of the blended levels, times v
   assign n2 = NW'(NW'(SEC) << QS) - NW'(pa0_ff);
   assign n3 = NW'(NW'(SEC) << QS) - NW'(pb0_ff);
   assign m2_1_in = MW'(v0_ff) * MW'(n2);
   assign m3_1_in = MW'(v0_ff) * MW'(n3);
   assign pv255   = {pv0_ff, 8'b0} - (V1W+8)'(pv0_ff);
   assign c1_1_in = CW'(pv255 >> (2 * QS));

   // stage 2: scale by 255, drop the power of two, start the divide by 15
   assign x2 = {m2_1_ff, 8'b0} - (MW+8)'(m2_1_ff);
   assign x3 = {m3_1_ff, 8'b0} - (MW+8)'(m3_1_ff);
   assign y2 = YW'(x2 >> DSH);
   assign y3 = YW'(x3 >> DSH);
   assign d2_2_in = PW'(y2) * PW'(hsv2rgb_pkg::DIV15_MUL);
   assign d3_2_in = PW'(y3) * PW'(hsv2rgb_pkg::DIV15_MUL);

   // stage 3: finish the divide and route by sector
   assign c2 = CW'(d2_2_ff >> hsv2rgb_pkg::DIV15_SHIFT);
   assign c3 = CW'(d3_2_ff >> hsv2rgb_pkg::DIV15_SHIFT);

   always_comb begin
      unique case (sec2_ff)
         hsv2rgb_pkg::SEC_RED_YEL: rsp_in = '{red: cv2_ff, green: c3, blue: c1_2_ff};
         hsv2rgb_pkg::SEC_YEL_GRN: rsp_in = '{red: c2, green: cv2_ff, blue: c1_2_ff};
         hsv2rgb_pkg::SEC_GRN_CYN: rsp_in = '{red: c1_2_ff, green: cv2_ff, blue: c3};
         hsv2rgb_pkg::SEC_CYN_BLU: rsp_in = '{red: c1_2_ff, green: c2, blue: cv2_ff};
         hsv2rgb_pkg::SEC_BLU_MAG: rsp_in = '{red: c3, green: c1_2_ff, blue: cv2_ff};
         default:                  rsp_in = '{red: cv2_ff, green: c1_2_ff, blue: c2};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff  <= 1'b0;
         valid1_ff  <= 1'b0;
         valid2_ff  <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         valid0_ff  <= take;
         valid1_ff  <= valid0_ff;
         valid2_ff  <= valid1_ff;
         rsp_strobe <= valid2_ff;
      end
      sec0_ff  <= sector;
      v0_ff    <= bri;
      pa0_ff   <= pa0_in;
      pb0_ff   <= pb0_in;
      pv0_ff   <= pv0_in;
      cv0_ff   <= cv0_in;
      sec1_ff  <= sec0_ff;
      m2_1_ff  <= m2_1_in;
      m3_1_ff  <= m3_1_in;
      c1_1_ff  <= c1_1_in;
      cv1_ff   <= cv0_ff;
      sec2_ff  <= sec1_ff;
      d2_2_ff  <= d2_2_in;
      d3_2_ff  <= d3_2_in;
      c1_2_ff  <= c1_1_ff;
      cv2_ff   <= cv1_ff;
      rsp_data <= rsp_in;
   end

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps
// top level of the hsv to rgb pixel converter
//
// converts one hsv pixel item to 8-bit rgb per clock
// input: an item is taken at a rising edge with start high and busy low;
//   hue is signed degrees << HUE_FRAC_BITS and wraps modulo 360 degrees,
//   saturation and brightness are Q1.16 and clamp at 1.0
// output: rsp_strobe is high for exactly one cycle per item with rsp_data valid;
//   the receiver cannot hold results off, so there is no backpressure path
// path: an accepted item passes through 3 front stages, the queue, 3 back stages
//   and the output register before rsp_strobe is high with its rsp_data
// throughput: one item per clock, set by the fully pipelined back end whose
//   deepest step is one multiplier per stage
// a front end wraps the hue and finds sector and remainder, a two entry queue
//   sits in between, and the back end builds the levels and picks the channels
// busy rises only when the queue is full; the back end drains one entry each
//   cycle it holds one, so in practice busy stays low
// reset is synchronous and empties the pipeline and the queue; items in flight
//   are dropped
module hsv_to_rgb_converter #(
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hsv2rgb_pkg::req_type req_data,
   output logic                 rsp_strobe,
   output hsv2rgb_pkg::rsp_type rsp_data
);

   localparam int SEC = 60 << HUE_FRAC_BITS;
   localparam int RW  = $clog2(SEC);
   localparam int LW  = hsv2rgb_pkg::LVL_W;
   localparam int EW  = 3 + RW + 2 * LW;   // sector, remainder, saturation, brightness

   logic                        accept;
   // front to queue
   logic                        push;
   hsv2rgb_pkg::sector_type     f_sector;
   logic [RW-1:0]               f_rem;
   logic [LW-1:0]               f_sat, f_bri;
   logic [EW-1:0]               wr_data;
   // queue to back
   logic [EW-1:0]               rd_data;
   hsv2rgb_pkg::fifo_status_type q_status;
   logic                        take;
   hsv2rgb_pkg::sector_type     b_sector;
   logic [RW-1:0]               b_rem;
   logic [LW-1:0]               b_sat, b_bri;

   assign busy   = q_status.full;
   assign accept = start && !busy;

   hsv2rgb_front #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .sector   (f_sector),
      .rem      (f_rem),
      .sat      (f_sat),
      .bri      (f_bri)
   );

   // pack one queue entry
   assign wr_data = {f_sector, f_rem, f_sat, f_bri};

   hsv2rgb_fifo #(
      .WIDTH(EW),
      .DEPTH(hsv2rgb_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_data),
      .pop     (take),
      .rd_data (rd_data),
      .status  (q_status)
   );

   // back end never stalls, so it takes an entry whenever one is there
   assign take     = !q_status.empty;
   assign b_sector = hsv2rgb_pkg::sector_type'(rd_data[EW-1 -: 3]);
   assign b_rem    = rd_data[2*LW +: RW];
   assign b_sat    = rd_data[LW +: LW];
   assign b_bri    = rd_data[0 +: LW];

   hsv2rgb_back #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .sector     (b_sector),
      .rem        (b_rem),
      .sat        (b_sat),
      .bri        (b_bri),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
